FILE: rtl/core/bls_pkg.sv
// ============================================================================
// bls_pkg: shared types and constants for the bounded LIFO stack
// Operation and status codes, sequencer states and default sizes.
// ============================================================================
package bls_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DEPTH_MAX     = 64;
    localparam int DATA_W        = 32;
    localparam int CAP_W         = 7;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DUMP = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DUMP
    } state_t;

endpackage

FILE: rtl/core/bounded_lifo_stack_top.sv
// ============================================================================
// bounded_lifo_stack_top: bounded last-in-first-out stack
// Push, pop, peek and dump over a DEPTH-entry store with a configurable limit.
// ============================================================================
//
//  Channel   Ports                                          Flow control
//  --------  ---------------------------------------------  ------------------
//  request   start, busy, func, push_value                  start && !busy
//  result    result_valid, result_value, status, last       strobe, no stall
//  config    cfg_we, cfg_wdata                              write on cfg_we
//
//  Push, and any request that fails, gives its result in the cycle after the
//  transfer. Pop and peek pass through the registered store read and then
//  the result register. Dump gives one entry per cycle through the single
//  store read port. busy is high while a pop, peek or dump is in progress.
//  Reset empties the stack, sets the limit to min(16, DEPTH), keeps the store.
//  Results are strobed for one cycle and cannot be held off.
//
module bounded_lifo_stack_top #(
    parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bls_pkg::FUNC_W-1:0]        func,
    input  logic signed [bls_pkg::DATA_W-1:0] push_value,
    input  logic                              cfg_we,
    input  logic [bls_pkg::CAP_W-1:0]         cfg_wdata,
    output logic                              result_valid,
    output logic signed [bls_pkg::DATA_W-1:0] result_value,
    output logic [bls_pkg::STATUS_W-1:0]      status,
    output logic                              last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [bls_pkg::CAP_W-1:0] DEPTH_CAP = bls_pkg::CAP_W'(DEPTH);

    logic [bls_pkg::DATA_W-1:0] mem [DEPTH];

    bls_pkg::state_t             state_reg, state_next;
    logic [bls_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [FW-1:0]               cnt_reg, cnt_next;
    logic [bls_pkg::CAP_W-1:0]   capacity_reg;
    logic [bls_pkg::DATA_W-1:0]  rd_data_reg;

    logic                        valid_reg, valid_next;
    logic [bls_pkg::DATA_W-1:0]  value_reg, value_next;
    logic [bls_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                        last_reg, last_next;

    logic [bls_pkg::CAP_W-1:0]   limit;
    logic                        full;
    logic                        empty;
    logic                        accept;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic [FW-1:0]               cnt_inc;

    assign limit   = (capacity_reg > DEPTH_CAP) ? DEPTH_CAP : capacity_reg;
    assign full    = (bls_pkg::CAP_W'(fill_reg) >= limit);
    assign empty   = (fill_reg == '0);
    assign accept  = start && (state_reg == bls_pkg::ST_IDLE);
    assign cnt_inc = cnt_reg + FW'(1);
    assign wr_addr = fill_reg[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        valid_next  = 1'b0;
        value_next  = '0;
        status_next = bls_pkg::STATUS_OK;
        last_next   = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = '0;

        case (state_reg)
            bls_pkg::ST_IDLE:
            begin
                rd_addr = AW'(fill_reg - FW'(1));
                if (accept)
                begin
                    func_next = func;
                    case (func)
                        bls_pkg::FUNC_PUSH:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (full)
                            begin
                                status_next = bls_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        bls_pkg::FUNC_POP,
                        bls_pkg::FUNC_PEEK:
                        begin
                            if (empty)
                            begin
                                valid_next  = 1'b1;
                                last_next   = 1'b1;
                                status_next = bls_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = bls_pkg::ST_EMIT;
                            end
                        end
                        default:
                        begin
                            // dump starts from the bottom entry
                            rd_addr  = '0;
                            cnt_next = '0;
                            if (empty)
                            begin
                                valid_next  = 1'b1;
                                last_next   = 1'b1;
                                status_next = bls_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = bls_pkg::ST_DUMP;
                            end
                        end
                    endcase
                end
            end
            bls_pkg::ST_EMIT:
            begin
                valid_next = 1'b1;
                last_next  = 1'b1;
                value_next = rd_data_reg;
                if (func_reg == bls_pkg::FUNC_POP)
                begin
                    fill_next = fill_reg - FW'(1);
                end
                state_next = bls_pkg::ST_IDLE;
            end
            bls_pkg::ST_DUMP:
            begin
                // emit the entry just read and fetch the next one
                rd_addr    = cnt_inc[AW-1:0];
                valid_next = 1'b1;
                value_next = rd_data_reg;
                cnt_next   = cnt_inc;
                if (cnt_inc == fill_reg)
                begin
                    last_next  = 1'b1;
                    state_next = bls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bls_pkg::ST_IDLE;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            func_reg     <= bls_pkg::FUNC_PUSH;
            capacity_reg <= bls_pkg::CAPACITY_RESET;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            func_reg  <= func_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy         = (state_reg != bls_pkg::ST_IDLE);
    assign result_valid = valid_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule
